>>> hdl/tlrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlrs_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ID_WIDTH    = 16;

    localparam int TASK_ID_W = 16;
    localparam int PRIO_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int TOTAL_W   = 8;
    localparam int RATIO_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam int NUM_LVL = 3;
    localparam int LVL_W   = 2;

    localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_HIGH = 2'd2;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [PRIO_W-1:0] PRI_LOW  = 2'd0;
    localparam logic [PRIO_W-1:0] PRI_MID  = 2'd1;
    localparam logic [PRIO_W-1:0] PRI_HIGH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HI_MID  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_LOW = 1'd1;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd10;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 8'd255;

    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } t_q_status;

    typedef struct packed {
        logic [NUM_LVL-1:0]  push;
        logic [NUM_LVL-1:0]  pop;
        logic [STATUS_W-1:0] status;
    } t_sched_ctl;

endpackage

`default_nettype wire

>>> hdl/three_level_ratio_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-level task scheduler. Each beat on the input channel either enqueues a task ID
// into the high, mid or low queue or dequeues the next task under the two turn ratios,
// and produces exactly one result beat. A new beat is taken every cycle while the output
// is not stalled. Each beat is first held in the input register; the scheduling decision
// is then registered together with the registered read of the queue memory that holds
// the picked ID. The ratio registers may be written only while no beat is in flight.

module three_level_ratio_scheduler_top #(
    parameter int QUEUE_DEPTH = tlrs_pkg::QUEUE_DEPTH,
    parameter int ID_WIDTH    = tlrs_pkg::ID_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tlrs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tlrs_pkg::RATIO_W-1:0]       i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_opcode,
    input  wire logic [tlrs_pkg::TASK_ID_W-1:0]     i_task_id,
    input  wire logic [tlrs_pkg::PRIO_W-1:0]        i_priority_req,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic      [tlrs_pkg::TASK_ID_W-1:0]     o_picked_id,
    output logic      [tlrs_pkg::STATUS_W-1:0]      o_status,
    output logic      [tlrs_pkg::TOTAL_W-1:0]       o_queued_total,
    output logic                                    o_all_empty
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = CW + 2;

    logic [tlrs_pkg::RATIO_W-1:0] r_hi_mid_ratio;
    logic [tlrs_pkg::RATIO_W-1:0] r_mid_low_ratio;

    logic                           r_in_valid;
    logic                           r_opcode;
    logic [tlrs_pkg::TASK_ID_W-1:0] r_task_id;
    logic [tlrs_pkg::PRIO_W-1:0]    r_prio;

    logic                          r_out_valid;
    logic                          r_out_pop;
    logic [tlrs_pkg::LVL_W-1:0]    r_out_lvl;
    logic [tlrs_pkg::STATUS_W-1:0] r_out_status;
    logic [tlrs_pkg::TOTAL_W-1:0]  r_out_total;
    logic                          r_out_all_empty;

    logic                       advance;
    logic                       fire;
    tlrs_pkg::t_sched_ctl       ctl;
    tlrs_pkg::t_q_status [tlrs_pkg::NUM_LVL-1:0] q_st;
    logic [CW-1:0]              q_count [tlrs_pkg::NUM_LVL];
    logic [ID_WIDTH-1:0]        q_data  [tlrs_pkg::NUM_LVL];
    logic [ID_WIDTH-1:0]        store_id;
    logic [TW-1:0]              n_total;
    logic [tlrs_pkg::LVL_W-1:0] n_lvl;
    logic [tlrs_pkg::TOTAL_W-1:0] n_total_sat;

    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;
    assign store_id   = ID_WIDTH'(r_task_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_mid_ratio  <= tlrs_pkg::RATIO_RESET;
            r_mid_low_ratio <= tlrs_pkg::RATIO_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlrs_pkg::CFG_HI_MID:  r_hi_mid_ratio  <= i_cfg_data;
                tlrs_pkg::CFG_MID_LOW: r_mid_low_ratio <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_opcode  <= i_opcode;
            r_task_id <= i_task_id;
            r_prio    <= i_priority_req;
        end
    end

    tlrs_arbiter u_arbiter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_opcode        (r_opcode),
        .i_prio          (r_prio),
        .i_qs            (q_st),
        .i_hi_mid_ratio  (r_hi_mid_ratio),
        .i_mid_low_ratio (r_mid_low_ratio),
        .o_ctl           (ctl)
    );

    for (genvar g = 0; g < tlrs_pkg::NUM_LVL; g++) begin : g_queue
        tlrs_queue #(
            .DEPTH (QUEUE_DEPTH),
            .WIDTH (ID_WIDTH)
        ) u_queue (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_push   (fire && ctl.push[g]),
            .i_pop    (fire && ctl.pop[g]),
            .i_data   (store_id),
            .o_q      (q_data[g]),
            .o_status (q_st[g]),
            .o_count  (q_count[g])
        );
    end

    always_comb begin
        n_total = TW'(q_count[tlrs_pkg::LVL_HIGH]) + TW'(q_count[tlrs_pkg::LVL_MID])
                  + TW'(q_count[tlrs_pkg::LVL_LOW]) + TW'(|ctl.push) - TW'(|ctl.pop);
        n_total_sat = (n_total > TW'(tlrs_pkg::TOTAL_MAX)) ? tlrs_pkg::TOTAL_MAX
                                                          : tlrs_pkg::TOTAL_W'(n_total);
        if (ctl.pop[tlrs_pkg::LVL_HIGH]) begin
            n_lvl = tlrs_pkg::LVL_HIGH;
        end else if (ctl.pop[tlrs_pkg::LVL_MID]) begin
            n_lvl = tlrs_pkg::LVL_MID;
        end else begin
            n_lvl = tlrs_pkg::LVL_LOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_pop       <= |ctl.pop;
            r_out_lvl       <= n_lvl;
            r_out_status    <= ctl.status;
            r_out_total     <= n_total_sat;
            r_out_all_empty <= (n_total == '0);
        end
    end

    always_comb begin
        o_picked_id = '0;
        if (r_out_pop) begin
            case (r_out_lvl)
                tlrs_pkg::LVL_HIGH: o_picked_id = tlrs_pkg::TASK_ID_W'(q_data[tlrs_pkg::LVL_HIGH]);
                tlrs_pkg::LVL_MID:  o_picked_id = tlrs_pkg::TASK_ID_W'(q_data[tlrs_pkg::LVL_MID]);
                default:            o_picked_id = tlrs_pkg::TASK_ID_W'(q_data[tlrs_pkg::LVL_LOW]);
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_queued_total = r_out_total;
    assign o_all_empty    = r_out_all_empty;

`ifndef SYNTHESIS
    a_one_queue_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> $onehot0({ctl.push, ctl.pop}))
        else $error("More than one queue operation in a single beat.");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_all_empty == (o_queued_total == '0)))
        else $error("All-empty flag disagrees with the queued total.");

    a_status_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ctl.status != tlrs_pkg::ST_OK) |-> (ctl.pop == '0 && ctl.push == '0))
        else $error("Queue changed on a beat that reported an error status.");
`endif

endmodule

`default_nettype wire

>>> hdl/tlrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tlrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/tlrs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tlrs_queue #(
    parameter int DEPTH = tlrs_pkg::QUEUE_DEPTH,
    parameter int WIDTH = tlrs_pkg::ID_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic                       i_pop,
    input  wire logic [WIDTH-1:0]           i_data,
    output logic      [WIDTH-1:0]           o_q,
    output tlrs_pkg::t_q_status             o_status,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [CW-1:0] n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (i_pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    tlrs_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_push),
        .i_waddr (r_tail),
        .i_wdata (i_data),
        .i_re    (i_pop),
        .i_raddr (r_head),
        .o_rdata (o_q)
    );

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.last  = (r_count == CW'(1));
    assign o_count        = r_count;

endmodule

`default_nettype wire

>>> hdl/tlrs_arbiter.sv
`timescale 1ns / 1ps
`default_nettype none

module tlrs_arbiter (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_fire,
    input  wire logic                                 i_opcode,
    input  wire logic [tlrs_pkg::PRIO_W-1:0]          i_prio,
    input  wire tlrs_pkg::t_q_status [tlrs_pkg::NUM_LVL-1:0] i_qs,
    input  wire logic [tlrs_pkg::RATIO_W-1:0]         i_hi_mid_ratio,
    input  wire logic [tlrs_pkg::RATIO_W-1:0]         i_mid_low_ratio,
    output tlrs_pkg::t_sched_ctl                      o_ctl
);

    logic                         r_hi_idle;
    logic [tlrs_pkg::RATIO_W-1:0] r_hi_cnt;
    logic                         r_lo_idle;
    logic [tlrs_pkg::RATIO_W-1:0] r_lo_cnt;
    logic                         n_hi_idle;
    logic [tlrs_pkg::RATIO_W-1:0] n_hi_cnt;
    logic                         n_lo_idle;
    logic [tlrs_pkg::RATIO_W-1:0] n_lo_cnt;

    logic all_empty;
    logic take_high;
    logic take_low;

    assign all_empty = i_qs[tlrs_pkg::LVL_HIGH].empty && i_qs[tlrs_pkg::LVL_MID].empty
                       && i_qs[tlrs_pkg::LVL_LOW].empty;
    assign take_high = !r_hi_idle
                       && (r_hi_cnt != '0 || (r_lo_idle && i_qs[tlrs_pkg::LVL_MID].empty));
    assign take_low  = (!r_lo_idle && r_lo_cnt == '0) || i_qs[tlrs_pkg::LVL_MID].empty;

    always_comb begin
        o_ctl        = '0;
        o_ctl.status = tlrs_pkg::ST_OK;
        n_hi_idle    = r_hi_idle;
        n_hi_cnt     = r_hi_cnt;
        n_lo_idle    = r_lo_idle;
        n_lo_cnt     = r_lo_cnt;
        if (i_opcode == tlrs_pkg::OP_ENQ) begin
            if (i_prio == tlrs_pkg::PRI_MID) begin
                if (i_qs[tlrs_pkg::LVL_MID].full) begin
                    o_ctl.status = tlrs_pkg::ST_OVERFLOW;
                end else begin
                    o_ctl.push[tlrs_pkg::LVL_MID] = 1'b1;
                end
            end else if (i_prio == tlrs_pkg::PRI_HIGH) begin
                if (i_qs[tlrs_pkg::LVL_HIGH].full) begin
                    o_ctl.status = tlrs_pkg::ST_OVERFLOW;
                end else begin
                    o_ctl.push[tlrs_pkg::LVL_HIGH] = 1'b1;
                    if (r_hi_idle) begin
                        n_hi_idle = 1'b0;
                        n_hi_cnt  = i_hi_mid_ratio;
                    end
                end
            end else begin
                if (i_qs[tlrs_pkg::LVL_LOW].full) begin
                    o_ctl.status = tlrs_pkg::ST_OVERFLOW;
                end else begin
                    o_ctl.push[tlrs_pkg::LVL_LOW] = 1'b1;
                    if (r_lo_idle) begin
                        n_lo_idle = 1'b0;
                        n_lo_cnt  = i_mid_low_ratio;
                    end
                end
            end
        end else if (all_empty) begin
            o_ctl.status = tlrs_pkg::ST_EMPTY;
        end else if (take_high) begin
            o_ctl.pop[tlrs_pkg::LVL_HIGH] = !i_qs[tlrs_pkg::LVL_HIGH].empty;
            if (i_qs[tlrs_pkg::LVL_HIGH].empty || i_qs[tlrs_pkg::LVL_HIGH].last) begin
                n_hi_idle = 1'b1;
            end else if (r_hi_cnt == '0) begin
                n_hi_cnt = i_hi_mid_ratio;
            end else begin
                n_hi_cnt = r_hi_cnt - 1'b1;
            end
        end else begin
            // High gives up its turn; its budget reloads for the next round.
            if (!r_hi_idle) begin
                n_hi_cnt = i_hi_mid_ratio;
            end
            if (take_low) begin
                o_ctl.pop[tlrs_pkg::LVL_LOW] = !i_qs[tlrs_pkg::LVL_LOW].empty;
                if (i_qs[tlrs_pkg::LVL_LOW].empty || i_qs[tlrs_pkg::LVL_LOW].last) begin
                    n_lo_idle = 1'b1;
                end else begin
                    n_lo_idle = 1'b0;
                    n_lo_cnt  = i_mid_low_ratio;
                end
            end else begin
                o_ctl.pop[tlrs_pkg::LVL_MID] = 1'b1;
                if (!r_lo_idle && r_lo_cnt != '0) begin
                    n_lo_cnt = r_lo_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_idle <= 1'b1;
            r_hi_cnt  <= '0;
            r_lo_idle <= 1'b1;
            r_lo_cnt  <= '0;
        end else if (i_fire) begin
            r_hi_idle <= n_hi_idle;
            r_hi_cnt  <= n_hi_cnt;
            r_lo_idle <= n_lo_idle;
            r_lo_cnt  <= n_lo_cnt;
        end
    end

endmodule

`default_nettype wire
